// ===== hw/rtl/rhd_pkg.sv =====
// ----------------------------------------------------------------------------
// rhd_pkg - shared types and constants for the replay history detector
// Result codes, register indexes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package rhd_pkg;

  localparam int unsigned HASH_W  = 32;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned THR_W   = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = 8'hFF;
  localparam logic [COUNT_W-1:0] COUNT_INIT = 8'd1;

  localparam logic [TIME_W-1:0] WINDOW_RESET    = 32'd5000;
  localparam logic [THR_W-1:0]  THRESHOLD_RESET = 8'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;

  // result outcome codes
  localparam logic [1:0] OUTCOME_INSERT = 2'd0;
  localparam logic [1:0] OUTCOME_MATCH  = 2'd1;
  localparam logic [1:0] OUTCOME_STALE  = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture input item, rewind scan address
    logic rd_en;   // read history entry at scan address
    logic update;  // resolve the matched entry and emit result
    logic insert;  // write new entry at ring head and emit result
  } rhd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;     // entry under compare is valid with equal hash
    logic last;    // entry under compare is the final one
  } rhd_stat_t;

endpackage

// ===== hw/rtl/rhd_ctrl.sv =====
// ----------------------------------------------------------------------------
// rhd_ctrl - scan controller
// Sequences capture, history scan, and match update or insertion.
// ----------------------------------------------------------------------------
module rhd_ctrl import rhd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  rhd_stat_t stat,
  output rhd_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_SCAN,
    ST_UPDATE,
    ST_INSERT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        priority if (stat.hit) begin
          state_nxt = ST_UPDATE;
        end else if (stat.last) begin
          state_nxt = ST_INSERT;
        end else begin
          cmd.rd_en = 1'b1;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_INSERT: begin
        cmd.insert = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ===== hw/rtl/rhd_dpath.sv =====
// ----------------------------------------------------------------------------
// rhd_dpath - history datapath
// History memories, valid bits, ring head, config registers and result regs.
// ----------------------------------------------------------------------------
module rhd_dpath import rhd_pkg::*; #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rhd_cmd_t              cmd,
  output rhd_stat_t             stat,
  input  logic [HASH_W-1:0]     in_hash,
  input  logic [TIME_W-1:0]     in_now,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  res_valid,
  output logic                  res_flag,
  output logic [1:0]            res_outcome
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  // history storage (no reset; guarded by valid bits)
  logic [HASH_W-1:0]  hash_mem  [ENTRIES];
  logic [TIME_W-1:0]  time_mem  [ENTRIES];
  logic [COUNT_W-1:0] count_mem [ENTRIES];
  logic [ENTRIES-1:0] valid_r;

  logic [IW-1:0]      head_r;
  logic [IW-1:0]      addr_r;
  logic [IW-1:0]      cmp_idx_r;
  logic [HASH_W-1:0]  key_hash_r;
  logic [TIME_W-1:0]  key_now_r;
  logic [HASH_W-1:0]  rd_hash_r;
  logic [TIME_W-1:0]  rd_time_r;
  logic [COUNT_W-1:0] rd_count_r;

  logic [TIME_W-1:0]  window_r;
  logic [THR_W-1:0]   thresh_r;

  logic               out_valid_r;
  logic               out_flag_r;
  logic [1:0]         out_outcome_r;

  logic [TIME_W-1:0]  age;
  logic               in_window;
  logic [COUNT_W-1:0] count_nxt;
  logic [IW-1:0]      head_nxt;

  assign stat.hit  = valid_r[cmp_idx_r] && (rd_hash_r == key_hash_r);
  assign stat.last = (cmp_idx_r == LAST_IDX);

  assign age       = key_now_r - rd_time_r;   // wraps mod 2^32
  assign in_window = (age < window_r);
  assign count_nxt = (rd_count_r == COUNT_MAX) ? rd_count_r : rd_count_r + COUNT_W'(1);
  assign head_nxt  = (head_r == LAST_IDX) ? '0 : head_r + IW'(1);

  // memory ports: one registered read, one write
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_hash_r  <= hash_mem[addr_r];
      rd_time_r  <= time_mem[addr_r];
      rd_count_r <= count_mem[addr_r];
    end
    if (cmd.update && in_window) begin
      time_mem[cmp_idx_r]  <= key_now_r;
      count_mem[cmp_idx_r] <= count_nxt;
    end else if (cmd.insert) begin
      hash_mem[head_r]  <= key_hash_r;
      time_mem[head_r]  <= key_now_r;
      count_mem[head_r] <= COUNT_INIT;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_hash_r <= in_hash;
      key_now_r  <= in_now;
    end
    if (cmd.load) begin
      addr_r <= '0;
    end else if (cmd.rd_en) begin
      addr_r <= addr_r + IW'(1);
    end
    if (cmd.rd_en) begin
      cmp_idx_r <= addr_r;
    end
    if (cmd.update) begin
      out_flag_r    <= in_window && (count_nxt >= thresh_r);
      out_outcome_r <= in_window ? OUTCOME_MATCH : OUTCOME_STALE;
    end else if (cmd.insert) begin
      out_flag_r    <= 1'b0;
      out_outcome_r <= OUTCOME_INSERT;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      head_r      <= '0;
      window_r    <= WINDOW_RESET;
      thresh_r    <= THRESHOLD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.update | cmd.insert;
      if (cmd.insert) begin
        valid_r[head_r] <= 1'b1;
        head_r          <= head_nxt;
      end
      if (cfg_we) begin
        if (cfg_idx == REG_WINDOW) begin
          window_r <= cfg_data;
        end else if (cfg_idx == REG_THRESHOLD) begin
          thresh_r <= cfg_data[THR_W-1:0];
        end
      end
    end
  end

  assign res_valid   = out_valid_r;
  assign res_flag    = out_flag_r;
  assign res_outcome = out_outcome_r;

endmodule

// ===== hw/rtl/replay_history_detector.sv =====
// ----------------------------------------------------------------------------
// replay_history_detector - top level
// Looks up a signal hash in a ring history and reports replayed signals.
// ----------------------------------------------------------------------------
//
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+--------------------
//  input     | in_signal_hash, in_now_ms               | start & !busy
//  result    | out_replay_flag, out_outcome            | out_valid, 1 cycle
//  config    | cfg_index, cfg_wdata                    | cfg_valid & cfg_ready
//
//  After its transfer an item passes through ST_ISSUE, ST_SCAN and then
//  ST_UPDATE (hit) or ST_INSERT (miss on the final entry); busy is high
//  while it does, and the result is registered. The scan time is set by the
//  single read port of the history memory: one entry is compared per
//  cycle, in index order, stopping at the first valid equal hash.
//  out_valid is high in the first cycle after busy falls, so the next item
//  can transfer at the edge that takes the result; the receiver cannot stall.
//  Synchronous active-low reset clears all valid bits, the ring head and the
//  result strobe, and restores window 5000 ms and threshold 3; no clearing
//  pass is needed. cfg_ready is always high; writes to unknown indexes are
//  dropped.
//
module replay_history_detector import rhd_pkg::*; #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  start,
  output logic                  busy,
  input  logic [HASH_W-1:0]     in_signal_hash,
  input  logic [TIME_W-1:0]     in_now_ms,
  // result channel
  output logic                  out_valid,
  output logic                  out_replay_flag,
  output logic [1:0]            out_outcome,
  // configuration channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  rhd_cmd_t  cmd;
  rhd_stat_t stat;

  // config writes are accepted at any time
  assign cfg_ready = 1'b1;

  rhd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  rhd_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_hash     (in_signal_hash),
    .in_now      (in_now_ms),
    .cfg_we      (cfg_valid & cfg_ready),
    .cfg_idx     (cfg_index),
    .cfg_data    (cfg_wdata),
    .res_valid   (out_valid),
    .res_flag    (out_replay_flag),
    .res_outcome (out_outcome)
  );

endmodule
